// ===== rtl/core/tsp_pkg.sv =====
// Shared types and constants for the transport stream packet aligner.
package tsp_pkg;

  localparam int unsigned DEF_PACKET_BYTES = 188;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [7:0] SYNC_RESET = 8'h47;

  // header positions: bytes 1..3 carry the header, byte 3 completes it
  localparam logic [7:0] HDR_FIRST_POS = 8'd1;
  localparam logic [7:0] HDR_LAST_POS  = 8'd3;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  pos;
    logic        last;
    logic        hdr_ready;
    logic [23:0] hdr;
  } tsp_entry_t;

  // push/pop handshake between the queue and its neighbors
  typedef struct packed {
    logic valid;
    logic ready;
  } tsp_hs_t;

endpackage

// ===== rtl/core/tsp_front.sv =====
// Front: hunts for sync, tracks byte position and collects header bytes.
module tsp_front import tsp_pkg::*; #(
  parameter int unsigned PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output tsp_hs_t    push,
  output tsp_entry_t push_entry,
  input  logic       push_full
);

  localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);

  logic [7:0]  sync_value;
  logic        in_packet;
  logic [7:0]  position_count;
  logic [23:0] header_bits;

  logic [7:0]  pos;
  logic [23:0] hdr_base;
  logic [23:0] hdr_next;
  logic        take;
  logic        last;

  assign in_ready = !push_full;

  always_comb begin
    pos      = in_packet ? position_count : 8'd0;
    hdr_base = in_packet ? header_bits : 24'd0;
    if (pos >= HDR_FIRST_POS && pos <= HDR_LAST_POS) begin
      hdr_next = {hdr_base[15:0], in_byte};
    end else begin
      hdr_next = hdr_base;
    end
    last = (pos >= LAST_POS);
    // outside a packet only a sync byte is kept
    take = in_valid && in_ready && (in_packet || in_byte == sync_value);
  end

  assign push.valid           = take;
  assign push.ready           = in_ready;
  assign push_entry.data      = in_byte;
  assign push_entry.pos       = pos;
  assign push_entry.last      = last;
  assign push_entry.hdr_ready = (pos >= HDR_LAST_POS);
  assign push_entry.hdr       = hdr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= SYNC_RESET;
      in_packet      <= 1'b0;
      position_count <= 8'd0;
      header_bits    <= 24'd0;
    end else begin
      if (cfg_wr_en) begin
        sync_value <= cfg_wr_data;
      end
      if (take) begin
        header_bits <= hdr_next;
        if (last) begin
          in_packet      <= 1'b0;
          position_count <= 8'd0;
        end else begin
          in_packet      <= 1'b1;
          position_count <= pos + 8'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tsp_queue.sv =====
// Short queue decoupling the front from the back.
module tsp_queue import tsp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  tsp_hs_t    push,
  input  tsp_entry_t push_entry,
  output logic       full,
  output tsp_hs_t    pop,
  input  logic       pop_take,
  output tsp_entry_t pop_entry
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  tsp_entry_t     mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CntFull);
  assign pop.valid = (count != '0);
  assign pop.ready = pop_take;
  assign pop_entry = mem[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop.valid && pop_take;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tsp_back.sv =====
// Back: decodes header fields and drives the registered output word.
module tsp_back import tsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tsp_hs_t     pop,
  output logic        pop_take,
  input  tsp_entry_t  pop_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_data,
  output logic        out_last,
  output logic        out_user
);

  logic [39:0] data_next;
  logic [23:0] hdr;

  assign pop_take = !out_valid || out_ready;

  always_comb begin
    hdr       = pop_entry.hdr_ready ? pop_entry.hdr : 24'd0;
    data_next = {hdr[3:0],    // continuity
                 hdr[5:4],    // adaptation control
                 hdr[7:6],    // scrambling
                 hdr[20:8],   // PID
                 hdr[21],     // priority
                 hdr[22],     // unit start
                 hdr[23],     // error
                 pop_entry.pos,
                 pop_entry.data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_take) begin
      out_valid <= pop.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_take && pop.valid) begin
      out_data <= data_next;
      out_last <= pop_entry.last;
      out_user <= pop_entry.hdr_ready;
    end
  end

endmodule

// ===== rtl/core/transport_stream_packet_aligner.sv =====
// Top level of the transport stream packet aligner.
//
//  channel  | dir | handshake                   | content
//  ---------+-----+-----------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | raw stream byte
//  m_axis   | out | m_axis_tvalid/m_axis_tready | packet byte, position, header
//  cfg      | in  | cfg_wr_en                   | sync byte value
//
// One word per cycle sustained while m_axis_tready stays high; a kept byte
// passes the queue write, then the output register, before it shows on m_axis.
// Bytes dropped while hunting produce no output word.
// rst is synchronous; after reset the block hunts for 0x47.
// s_axis_tready drops only when the two-entry queue is full, i.e. when the
// output register is held by m_axis_tready low and the queue has backed up.
module transport_stream_packet_aligner import tsp_pkg::*; #(
  parameter int unsigned PACKET_BYTES = DEF_PACKET_BYTES  // 5..255
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // sync_value
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] stream_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] packet_byte, [15:8] byte_position, [16] error_flag,
  // [17] unit_start, [18] priority_flag, [31:19] stream_id,
  // [33:32] scramble_mode, [35:34] adapt_mode, [39:36] continuity
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,    // packet_end
  output logic        m_axis_tuser     // [0] header_ready
);

  tsp_hs_t    push;
  tsp_entry_t push_entry;
  logic       q_full;
  tsp_hs_t    pop;
  logic       pop_take;
  tsp_entry_t pop_entry;

  // sync hunt, position count, header capture
  tsp_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .push       (push),
    .push_entry (push_entry),
    .push_full  (q_full)
  );

  // decoupling queue
  tsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .pop_take  (pop_take),
    .pop_entry (pop_entry)
  );

  // header decode and output register
  tsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_take (pop_take),
    .pop_entry(pop_entry),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast),
    .out_user (m_axis_tuser)
  );

endmodule
